>>> hw/rtl/nmfe_pkg.sv
`timescale 1ns / 1ps

package nmfe_pkg;

	// Default sizes of the mailbox table.
	localparam int DEF_NUM_BOXES  = 16;
	localparam int DEF_BOX_DEPTH  = 8;
	localparam int DEF_MSG_BYTES  = 8;
	localparam int DEF_NAME_BYTES = 8;
	localparam int DEF_MAX_USERS  = 255;

	// Operation codes.
	localparam logic [1:0] OP_OPEN  = 2'd0;
	localparam logic [1:0] OP_CLOSE = 2'd1;
	localparam logic [1:0] OP_SEND  = 2'd2;
	localparam logic [1:0] OP_RECV  = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_EMPTY_NAME = 3'd4;
	localparam logic [2:0] ST_NOT_OPEN   = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic exec;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_hit;
		logic scan_last;
	} dp_stat_t;

	// Keep the low name bytes up to, but not including, the first zero byte.
	function automatic logic [63:0] tidy_name(input logic [63:0] v, input int nbytes);
		logic [63:0] r;
		logic        live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (live && (i < nbytes) && (v[8*i +: 8] != 8'd0)) begin
				r[8*i +: 8] = v[8*i +: 8];
			end else begin
				live = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/nmfe_msgram.sv
`timescale 1ns / 1ps

module nmfe_msgram #(
	parameter int DEPTH = 128,
	parameter int BYTES = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [BYTES-1:0]         be,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [8*BYTES-1:0]       wdata,
	output logic [8*BYTES-1:0]       rdata
);

	logic [8*BYTES-1:0] mem [DEPTH];

	// Byte-lane write; unselected lanes keep their old contents.
	always_ff @(posedge clk) begin
		for (int k = 0; k < BYTES; k++) begin
			if (we && be[k]) begin
				mem[addr][8*k +: 8] <= wdata[8*k +: 8];
			end
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hw/rtl/nmfe_ctrl.sv
`timescale 1ns / 1ps

module nmfe_ctrl import nmfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	// Next state: an open with a usable name scans the table first.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = stat.need_scan ? S_SCAN : S_EXEC;
				end
			end
			S_SCAN: begin
				if (stat.scan_hit || stat.scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.scan   = (state_q == S_SCAN);
		cmd.exec   = (state_q == S_EXEC);
		cmd.finish = (state_q == S_FIN);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> hw/rtl/nmfe_dp.sv
`timescale 1ns / 1ps

module nmfe_dp import nmfe_pkg::*; #(
	parameter int NUM_BOXES  = DEF_NUM_BOXES,
	parameter int BOX_DEPTH  = DEF_BOX_DEPTH,
	parameter int MSG_BYTES  = DEF_MSG_BYTES,
	parameter int NAME_BYTES = DEF_NAME_BYTES,
	parameter int MAX_USERS  = DEF_MAX_USERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  operation,
	input  logic [3:0]  box_id,
	input  logic [63:0] box_name,
	input  logic [63:0] message_data,
	input  logic [3:0]  byte_count,
	output logic [2:0]  status,
	output logic [3:0]  granted_box,
	output logic [63:0] received_data,
	output logic        box_full,
	output logic        box_empty
);

	localparam int BW      = $clog2(NUM_BOXES);
	localparam int CW      = $clog2(2 * BOX_DEPTH);
	localparam int CNT_MOD = 2 * BOX_DEPTH;
	localparam int AW      = $clog2(NUM_BOXES * BOX_DEPTH);
	localparam int MW      = 8 * MSG_BYTES;
	localparam int NW      = 8 * NAME_BYTES;

	// Occupancy of a ring from its write and read counts.
	function automatic logic [CW-1:0] fill_of(input logic [CW-1:0] w, input logic [CW-1:0] r);
		logic [CW:0] sum;
		sum = {1'b0, w} + (CW+1)'(CNT_MOD) - {1'b0, r};
		return (w >= r) ? (w - r) : sum[CW-1:0];
	endfunction

	// Slot in the ring for a count that runs modulo twice the depth.
	function automatic logic [CW-1:0] slot_of(input logic [CW-1:0] c);
		return (c >= CW'(BOX_DEPTH)) ? (c - CW'(BOX_DEPTH)) : c;
	endfunction

	// Request registers.
	logic [1:0]    op_q;
	logic [BW-1:0] box_q;
	logic          box_ok_q;
	logic [NW-1:0] name_q;
	logic [MW-1:0] data_q;
	logic [3:0]    cnt_q;

	// Mailbox tables.
	logic [NW-1:0]        name_tbl [NUM_BOXES];
	logic [7:0]           users_q  [NUM_BOXES];
	logic [CW-1:0]        wcnt_q   [NUM_BOXES];
	logic [CW-1:0]        rcnt_q   [NUM_BOXES];
	logic [NUM_BOXES-1:0] in_use_q;

	// Name scan state.
	logic [BW-1:0] scan_idx_q;
	logic          hit_q;
	logic          free_found_q;
	logic [BW-1:0] free_idx_q;

	// Execute-stage results.
	logic [BW-1:0] fb_q;
	logic          fv_q;
	logic          recv_q;
	logic [2:0]    status_q;
	logic [3:0]    granted_q;
	logic [63:0]   rdata_q;
	logic          full_q;
	logic          empty_q;

	logic [BW-1:0]        ex_tgt;
	logic [CW-1:0]        ex_w;
	logic [CW-1:0]        ex_r;
	logic [CW-1:0]        ex_fill;
	logic                 ex_full;
	logic                 ex_empty;
	logic [2:0]           ex_status;
	logic                 ex_fv;
	logic                 ex_grant;
	logic                 ex_send;
	logic                 ex_recv;
	logic [7:0]           ex_unew;
	logic [CW-1:0]        fin_fill;
	logic [MSG_BYTES-1:0] byte_en;
	logic [MW-1:0]        byte_mask;
	logic [AW-1:0]        mem_addr;
	logic [MW-1:0]        mem_rdata;
	logic [63:0]          name_clean;
	logic [3:0]           cnt_sat;

	// Input cleanup: trim the name and saturate the byte count.
	assign name_clean = tidy_name(box_name, NAME_BYTES);
	assign cnt_sat    = (byte_count > 4'(MSG_BYTES)) ? 4'(MSG_BYTES) : byte_count;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			box_q    <= BW'(box_id);
			box_ok_q <= (int'(box_id) < NUM_BOXES);
			name_q   <= name_clean[NW-1:0];
			data_q   <= message_data[MW-1:0];
			cnt_q    <= cnt_sat;
		end
	end

	// The controller scans the table only for an open with a nonempty name.
	assign stat.need_scan = (operation == OP_OPEN) && (box_name[7:0] != 8'd0);
	assign stat.scan_hit  = in_use_q[scan_idx_q] && (name_tbl[scan_idx_q] == name_q);
	assign stat.scan_last = (scan_idx_q == BW'(NUM_BOXES - 1));

	// One table entry per cycle: stop on a match, remember the first free box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else if (cmd.load) begin
			scan_idx_q   <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (stat.scan_hit) begin
				hit_q <= 1'b1;
			end else begin
				if (!in_use_q[scan_idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_idx_q;
				end
				scan_idx_q <= scan_idx_q + BW'(1);
			end
		end
	end

	// Box addressed by the request: the found or claimed box for an open.
	always_comb begin
		ex_tgt = box_q;
		if (op_q == OP_OPEN) begin
			ex_tgt = hit_q ? scan_idx_q : free_idx_q;
		end
	end

	assign ex_w     = wcnt_q[ex_tgt];
	assign ex_r     = rcnt_q[ex_tgt];
	assign ex_fill  = fill_of(ex_w, ex_r);
	assign ex_full  = (ex_fill >= CW'(BOX_DEPTH));
	assign ex_empty = (ex_fill == '0);
	assign ex_unew  = (users_q[ex_tgt] != 8'd0) ? (users_q[ex_tgt] - 8'd1) : 8'd0;

	// Decide the outcome of the request.
	always_comb begin
		ex_status = ST_OK;
		ex_fv     = 1'b0;
		ex_grant  = 1'b0;
		ex_send   = 1'b0;
		ex_recv   = 1'b0;
		priority if (op_q == OP_OPEN) begin
			if (name_q == '0) begin
				ex_status = ST_EMPTY_NAME;
			end else if (hit_q || free_found_q) begin
				ex_fv    = 1'b1;
				ex_grant = 1'b1;
			end else begin
				ex_status = ST_TABLE_FULL;
			end
		end else if (!box_ok_q) begin
			ex_status = ST_NOT_OPEN;
		end else if (!in_use_q[box_q]) begin
			ex_fv     = 1'b1;
			ex_status = ST_NOT_OPEN;
		end else if (op_q == OP_SEND) begin
			ex_fv = 1'b1;
			if (ex_full) begin
				ex_status = ST_FULL;
			end else begin
				ex_send = 1'b1;
			end
		end else if (op_q == OP_RECV) begin
			ex_fv = 1'b1;
			if (ex_empty) begin
				ex_status = ST_EMPTY;
			end else begin
				ex_recv = 1'b1;
			end
		end else begin
			ex_fv = 1'b1;
		end
	end

	// Update the control tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < NUM_BOXES; i++) begin
				users_q[i] <= 8'd0;
				wcnt_q[i]  <= '0;
				rcnt_q[i]  <= '0;
			end
		end else if (cmd.exec) begin
			if (ex_grant) begin
				if (hit_q) begin
					if (users_q[ex_tgt] < 8'(MAX_USERS)) begin
						users_q[ex_tgt] <= users_q[ex_tgt] + 8'd1;
					end
				end else begin
					in_use_q[ex_tgt] <= 1'b1;
					users_q[ex_tgt]  <= 8'd1;
				end
			end
			if (ex_send) begin
				wcnt_q[ex_tgt] <= (ex_w == CW'(CNT_MOD - 1)) ? '0 : ex_w + CW'(1);
			end
			if (ex_recv) begin
				rcnt_q[ex_tgt] <= (ex_r == CW'(CNT_MOD - 1)) ? '0 : ex_r + CW'(1);
			end
			if ((op_q == OP_CLOSE) && ex_fv && (ex_status == ST_OK)) begin
				users_q[ex_tgt] <= ex_unew;
				if (ex_unew == 8'd0) begin
					in_use_q[ex_tgt] <= 1'b0;
					wcnt_q[ex_tgt]   <= '0;
					rcnt_q[ex_tgt]   <= '0;
				end
			end
		end
	end

	// A claimed box takes the new name; free entries never match.
	always_ff @(posedge clk) begin
		if (cmd.exec && ex_grant && !hit_q) begin
			name_tbl[ex_tgt] <= name_q;
		end
	end

	// Byte lanes below the request count.
	always_comb begin
		for (int k = 0; k < MSG_BYTES; k++) begin
			byte_en[k]          = (4'(k) < cnt_q);
			byte_mask[8*k +: 8] = {8{byte_en[k]}};
		end
	end

	assign mem_addr = AW'(int'(ex_tgt) * BOX_DEPTH) + AW'(slot_of(ex_send ? ex_w : ex_r));

	nmfe_msgram #(
		.DEPTH (NUM_BOXES * BOX_DEPTH),
		.BYTES (MSG_BYTES)
	) u_msgram (
		.clk   (clk),
		.we    (cmd.exec && ex_send),
		.re    (cmd.exec && ex_recv),
		.be    (byte_en),
		.addr  (mem_addr),
		.wdata (data_q),
		.rdata (mem_rdata)
	);

	// Execute-stage result registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= ex_status;
			granted_q <= ex_grant ? 4'(ex_tgt) : 4'd0;
			fv_q      <= ex_fv;
			fb_q      <= ex_tgt;
			recv_q    <= ex_recv;
		end
	end

	assign fin_fill = fill_of(wcnt_q[fb_q], rcnt_q[fb_q]);

	// Final stage: masked read data and the flags of the box after the update.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rdata_q <= recv_q ? 64'(mem_rdata & byte_mask) : 64'd0;
			full_q  <= fv_q && (fin_fill >= CW'(BOX_DEPTH));
			empty_q <= fv_q && (fin_fill == '0);
		end
	end

	assign status        = status_q;
	assign granted_box   = granted_q;
	assign received_data = rdata_q;
	assign box_full      = full_q;
	assign box_empty     = empty_q;

endmodule

>>> hw/rtl/named_mailbox_fifo_engine.sv
// Named mailbox engine: a table of NUM_BOXES named mailboxes, each a ring of BOX_DEPTH
// messages. A request is taken when start is high and busy is low; its single result
// appears on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. Close, send, receive and an open with an empty name go straight to
// the execute and finish states. An open with a nonempty name first compares the name
// against one table entry per cycle and stops at the first match or after the last
// entry. Message storage is a single-port memory with no reset; there is no clearing
// pass, and the block accepts requests right after reset.
`timescale 1ns / 1ps

module named_mailbox_fifo_engine import nmfe_pkg::*; #(
	parameter int NUM_BOXES  = DEF_NUM_BOXES,
	parameter int BOX_DEPTH  = DEF_BOX_DEPTH,
	parameter int MSG_BYTES  = DEF_MSG_BYTES,
	parameter int NAME_BYTES = DEF_NAME_BYTES,
	parameter int MAX_USERS  = DEF_MAX_USERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [3:0]  box_id,
	input  logic [63:0] box_name,
	input  logic [63:0] message_data,
	input  logic [3:0]  byte_count,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  granted_box,
	output logic [63:0] received_data,
	output logic        box_full,
	output logic        box_empty
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequencer.
	nmfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Tables, message memory and result registers.
	nmfe_dp #(
		.NUM_BOXES  (NUM_BOXES),
		.BOX_DEPTH  (BOX_DEPTH),
		.MSG_BYTES  (MSG_BYTES),
		.NAME_BYTES (NAME_BYTES),
		.MAX_USERS  (MAX_USERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.box_id        (box_id),
		.box_name      (box_name),
		.message_data  (message_data),
		.byte_count    (byte_count),
		.status        (status),
		.granted_box   (granted_box),
		.received_data (received_data),
		.box_full      (box_full),
		.box_empty     (box_empty)
	);

	// A result only follows a request in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// A taken request keeps the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// A refused request returns no message bytes.
	a_no_data_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (received_data == 64'd0))
		else $error("data returned with a failing status");

	// A box cannot be full and empty at once.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(box_full && box_empty))
		else $error("box reported full and empty");

endmodule
